// File: hw/rtl/prcu_pkg.sv
// ----------------------------------------------------------------------------
// prcu_pkg: shared types and constants of the polar/rectangular point unit
// Operation codes, CORDIC arctangent table, gain constant and stage payloads.
// ----------------------------------------------------------------------------
package prcu_pkg;

  // operation codes carried in the mode field
  localparam logic [2:0] MODE_R2P   = 3'd0;
  localparam logic [2:0] MODE_P2R   = 3'd1;
  localparam logic [2:0] MODE_ROT   = 3'd2;
  localparam logic [2:0] MODE_SCALE = 3'd3;
  localparam logic [2:0] MODE_ADD   = 3'd4;
  localparam logic [2:0] MODE_SUB   = 3'd5;

  localparam int unsigned GUARD_BITS = 8;
  // rotation lanes: |x|,|y| stay below 2^40
  localparam int unsigned ROT_W  = 44;
  localparam int unsigned ROT_ZW = 34;
  // vectoring lanes: sum of two points after CORDIC growth stays below 2^43
  localparam int unsigned VEC_W  = 46;

  localparam logic [31:0] INV_GAIN     = 32'd2608131496;  // 1/K in Q0.32
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // atan(2^-i) in binary-angle units
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                     rot;  // lane takes part in rotation
    logic signed [ROT_W-1:0]  x;
    logic signed [ROT_W-1:0]  y;
    logic signed [ROT_ZW-1:0] z;
  } rot_lane_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [31:0]             z;
  } vec_lane_t;

  // per-transaction sideband traveling with the lanes
  typedef struct packed {
    logic [2:0]  mode;
    logic [30:0] rad;
    logic [31:0] ang;
    logic [31:0] xo;
    logic [31:0] yo;
    logic        ov;
    logic        zero;
  } side_t;

  typedef struct packed {
    logic [30:0] rad;
    logic [31:0] ang;
    logic [31:0] xo;
    logic [31:0] yo;
    logic        ov;
  } res_t;

endpackage

// File: hw/rtl/prcu_in_if.sv
// ----------------------------------------------------------------------------
// prcu_in_if: operation channel of the point unit
// Valid/ready channel carrying one operation per transaction.
// ----------------------------------------------------------------------------
interface prcu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic signed [31:0] radius_in;
  logic [31:0]        angle_in;
  logic [31:0]        delta_angle;
  logic signed [31:0] scale_factor;
  logic signed [31:0] other_radius;
  logic [31:0]        other_angle;

  modport source (
    output valid, mode, x_in, y_in, radius_in, angle_in, delta_angle,
           scale_factor, other_radius, other_angle,
    input  ready
  );
  modport sink (
    input  valid, mode, x_in, y_in, radius_in, angle_in, delta_angle,
           scale_factor, other_radius, other_angle,
    output ready
  );
endinterface

// File: hw/rtl/prcu_out_if.sv
// ----------------------------------------------------------------------------
// prcu_out_if: result channel of the point unit
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface prcu_out_if;
  logic               valid;
  logic               ready;
  logic [30:0]        radius_out;
  logic [31:0]        angle_out;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic               overflow;

  modport source (
    output valid, radius_out, angle_out, x_out, y_out, overflow,
    input  ready
  );
  modport sink (
    input  valid, radius_out, angle_out, x_out, y_out, overflow,
    output ready
  );
endinterface

// File: hw/rtl/prcu_rot_cell.sv
// ----------------------------------------------------------------------------
// prcu_rot_cell: one CORDIC rotation step for two lanes
// Micro-rotation by atan(2^-STEP), driven by the sign of the residual angle.
// ----------------------------------------------------------------------------
module prcu_rot_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  prcu_pkg::rot_lane_t lane_a_i,
  input  prcu_pkg::rot_lane_t lane_b_i,
  input  prcu_pkg::side_t     side_i,
  output logic                valid_o,
  output prcu_pkg::rot_lane_t lane_a_o,
  output prcu_pkg::rot_lane_t lane_b_o,
  output prcu_pkg::side_t     side_o
);

  localparam logic signed [prcu_pkg::ROT_ZW-1:0] TZ =
    {{(prcu_pkg::ROT_ZW-32){1'b0}}, prcu_pkg::ATAN_TAB[STEP]};

  function automatic prcu_pkg::rot_lane_t step(input prcu_pkg::rot_lane_t l);
    logic signed [prcu_pkg::ROT_W-1:0]  x;
    logic signed [prcu_pkg::ROT_W-1:0]  y;
    logic signed [prcu_pkg::ROT_W-1:0]  dx;
    logic signed [prcu_pkg::ROT_W-1:0]  dy;
    logic signed [prcu_pkg::ROT_ZW-1:0] z;
    prcu_pkg::rot_lane_t                r;
    x  = l.x;
    y  = l.y;
    z  = l.z;
    dx = y >>> STEP;
    dy = x >>> STEP;
    r  = l;
    if (l.rot) begin
      if (!z[prcu_pkg::ROT_ZW-1]) begin
        r.x = x - dx;
        r.y = y + dy;
        r.z = z - TZ;
      end else begin
        r.x = x + dx;
        r.y = y - dy;
        r.z = z + TZ;
      end
    end
    return r;
  endfunction

  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_a_o <= step(lane_a_i);
      lane_b_o <= step(lane_b_i);
      side_o   <= side_i;
    end
  end

  assign valid_o = valid_q;

endmodule

// File: hw/rtl/prcu_vec_cell.sv
// ----------------------------------------------------------------------------
// prcu_vec_cell: one CORDIC vectoring step
// Drives y toward zero and accumulates the angle taken.
// ----------------------------------------------------------------------------
module prcu_vec_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  prcu_pkg::vec_lane_t lane_i,
  input  prcu_pkg::side_t     side_i,
  output logic                valid_o,
  output prcu_pkg::vec_lane_t lane_o,
  output prcu_pkg::side_t     side_o
);

  localparam logic [31:0] T = prcu_pkg::ATAN_TAB[STEP];

  logic signed [prcu_pkg::VEC_W-1:0] x;
  logic signed [prcu_pkg::VEC_W-1:0] y;
  logic signed [prcu_pkg::VEC_W-1:0] dx;
  logic signed [prcu_pkg::VEC_W-1:0] dy;
  prcu_pkg::vec_lane_t               lane_d;
  logic                              valid_q;

  always_comb begin
    x      = lane_i.x;
    y      = lane_i.y;
    dx     = y >>> STEP;
    dy     = x >>> STEP;
    lane_d = lane_i;
    if (!y[prcu_pkg::VEC_W-1]) begin
      lane_d.x = x + dx;
      lane_d.y = y - dy;
      lane_d.z = lane_i.z + T;
    end else begin
      lane_d.x = x - dx;
      lane_d.y = y + dy;
      lane_d.z = lane_i.z - T;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o <= lane_d;
      side_o <= side_i;
    end
  end

  assign valid_o = valid_q;

endmodule

// File: hw/rtl/polar_rectangular_point_unit_top.sv
// ----------------------------------------------------------------------------
// polar_rectangular_point_unit_top: pipelined CORDIC point unit
// Rect/polar conversion, rotate, scale, polar add/sub; one result per op.
// ----------------------------------------------------------------------------
//  channel | dir | transaction payload
//  --------+-----+----------------------------------------------------------
//  in_i    | in  | mode, x_in, y_in, radius_in, angle_in, delta_angle,
//          |     | scale_factor, other_radius, other_angle
//  out_o   | out | radius_out, angle_out, x_out, y_out, overflow
//
//  One transaction per cycle while the skid register is empty; the path runs
//  through the rotation cell row followed by the vectoring cell row.
//  Reset (rst_ni low) clears only the stage, output and skid valid bits.
//  All stages advance together while the skid register is empty; a stalled
//  output parks one result in the skid register and then stops intake.
// ----------------------------------------------------------------------------
module polar_rectangular_point_unit_top #(
  parameter int unsigned CORDIC_STEPS = 24,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  prcu_in_if.sink    in_i,
  prcu_out_if.source out_o
);

  localparam int unsigned RW  = prcu_pkg::ROT_W;
  localparam int unsigned ZW  = prcu_pkg::ROT_ZW;
  localparam int unsigned VW  = prcu_pkg::VEC_W;
  localparam int unsigned G   = prcu_pkg::GUARD_BITS;
  localparam int unsigned RGW = 32 + G;  // width of a gain-corrected radius

  // stage enable: whole pipe moves while the skid register is free
  logic en;
  logic out_v_q, skid_v_q;
  prcu_pkg::res_t out_q, skid_q, res_d;

  assign en         = !skid_v_q;
  assign in_i.ready = en;

  // --------------------------------------------------------------------------
  // P0: input register
  // --------------------------------------------------------------------------
  logic               p0_v_q;
  logic [2:0]         p0_mode_q;
  logic signed [31:0] p0_x_q, p0_y_q, p0_r1_q, p0_f_q, p0_r2_q;
  logic [31:0]        p0_a1_q, p0_da_q, p0_a2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
    end else if (en) begin
      p0_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_mode_q <= in_i.mode;
      p0_x_q    <= in_i.x_in;
      p0_y_q    <= in_i.y_in;
      p0_r1_q   <= in_i.radius_in;
      p0_a1_q   <= in_i.angle_in;
      p0_da_q   <= in_i.delta_angle;
      p0_f_q    <= in_i.scale_factor;
      p0_r2_q   <= in_i.other_radius;
      p0_a2_q   <= in_i.other_angle;
    end
  end

  // --------------------------------------------------------------------------
  // A: sign fold of radii/factor, angle updates, gain and scale multiplies
  // --------------------------------------------------------------------------
  logic [31:0] a_mag1_d, a_mag2_d, a_magf_d, a_ang1_d, a_ang2_d, a_angr_d;

  always_comb begin
    a_mag1_d = p0_r1_q[31] ? (~p0_r1_q + 32'd1) : p0_r1_q;
    a_mag2_d = p0_r2_q[31] ? (~p0_r2_q + 32'd1) : p0_r2_q;
    a_magf_d = p0_f_q[31]  ? (~p0_f_q + 32'd1)  : p0_f_q;
    a_ang1_d = p0_a1_q + (p0_r1_q[31] ? prcu_pkg::HALF_TURN : 32'd0);
    a_ang2_d = p0_a2_q + (p0_r2_q[31] ? prcu_pkg::HALF_TURN : 32'd0);
    unique case (p0_mode_q)
      prcu_pkg::MODE_ROT:   a_angr_d = a_ang1_d + p0_da_q;
      prcu_pkg::MODE_SCALE: a_angr_d = a_ang1_d +
                                       (p0_f_q[31] ? prcu_pkg::HALF_TURN : 32'd0);
      default:              a_angr_d = a_ang1_d;
    endcase
  end

  logic               a_v_q;
  logic [2:0]         a_mode_q;
  logic [31:0]        a_mag1_q, a_ang1_q, a_ang2_q, a_angr_q;
  logic [63:0]        a_plo1_q, a_plo2_q, a_prod_q;
  logic [RGW-1:0]     a_phi1_q, a_phi2_q;
  logic signed [31:0] a_x_q, a_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= p0_v_q;
    end
  end

  // (mag << G) * 1/K split into a low 32x32 and a high Gx32 partial product
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mode_q <= p0_mode_q;
      a_mag1_q <= a_mag1_d;
      a_ang1_q <= a_ang1_d;
      a_ang2_q <= a_ang2_d;
      a_angr_q <= a_angr_d;
      a_x_q    <= p0_x_q;
      a_y_q    <= p0_y_q;
      a_plo1_q <= {32'd0, a_mag1_d[31-G:0], {G{1'b0}}} * {32'd0, prcu_pkg::INV_GAIN};
      a_plo2_q <= {32'd0, a_mag2_d[31-G:0], {G{1'b0}}} * {32'd0, prcu_pkg::INV_GAIN};
      a_phi1_q <= {32'd0, a_mag1_d[31:32-G]} * {{G{1'b0}}, prcu_pkg::INV_GAIN};
      a_phi2_q <= {32'd0, a_mag2_d[31:32-G]} * {{G{1'b0}}, prcu_pkg::INV_GAIN};
      a_prod_q <= {32'd0, a_mag1_d} * {32'd0, a_magf_d};
    end
  end

  // --------------------------------------------------------------------------
  // B: rounding, quadrant pre-rotation, direct-result saturation
  // --------------------------------------------------------------------------
  function automatic prcu_pkg::rot_lane_t mk_lane(input logic [RGW-1:0] rg,
                                                  input logic [31:0] ang,
                                                  input logic rot);
    logic [31:0]          q;
    logic [31:0]          zs;
    logic signed [RW-1:0] xv;
    prcu_pkg::rot_lane_t  l;
    q  = ang + prcu_pkg::QUARTER_TURN;
    xv = {{(RW-RGW){1'b0}}, rg};
    zs = ang;
    if (q[31]) begin
      xv = -xv;
      zs = ang - prcu_pkg::HALF_TURN;
    end
    l.rot = rot;
    l.x   = xv;
    l.y   = '0;
    l.z   = {{(ZW-32){zs[31]}}, zs};
    return l;
  endfunction

  logic [RGW-1:0]      rg1, rg2;
  logic [63:0]         scl;
  prcu_pkg::rot_lane_t b_l1_d, b_l2_d;
  prcu_pkg::side_t     b_sb_d;

  always_comb begin
    rg1    = a_phi1_q + RGW'((a_plo1_q + 64'h0000_0000_8000_0000) >> 32);
    rg2    = a_phi2_q + RGW'((a_plo2_q + 64'h0000_0000_8000_0000) >> 32);
    scl    = (a_prod_q + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    b_l1_d = mk_lane(rg1, a_ang1_q, 1'b0);
    b_l2_d = '0;
    b_sb_d = '0;
    b_sb_d.mode = a_mode_q;
    unique case (a_mode_q)
      prcu_pkg::MODE_R2P: begin
        // point passes the rotation row unrotated on to the vectoring row
        b_l1_d.x = {{(RW-32-G){a_x_q[31]}}, a_x_q, {G{1'b0}}};
        b_l1_d.y = {{(RW-32-G){a_y_q[31]}}, a_y_q, {G{1'b0}}};
        b_l1_d.z = '0;
      end
      prcu_pkg::MODE_P2R, prcu_pkg::MODE_ROT: begin
        b_l1_d.rot = (a_mode_q == prcu_pkg::MODE_P2R);
        b_sb_d.ang = a_angr_q;
        b_sb_d.ov  = a_mag1_q[31];
        b_sb_d.rad = a_mag1_q[31] ? 31'h7FFF_FFFF : a_mag1_q[30:0];
      end
      prcu_pkg::MODE_SCALE: begin
        b_sb_d.ang = a_angr_q;
        b_sb_d.ov  = |scl[63:31];
        b_sb_d.rad = (|scl[63:31]) ? 31'h7FFF_FFFF : scl[30:0];
      end
      prcu_pkg::MODE_ADD, prcu_pkg::MODE_SUB: begin
        b_l1_d.rot = 1'b1;
        b_l2_d     = mk_lane(rg2, a_ang2_q, 1'b1);
      end
      default: begin
        b_l1_d = '0;
      end
    endcase
  end

  logic                rv  [CORDIC_STEPS+1];
  prcu_pkg::rot_lane_t rl1 [CORDIC_STEPS+1];
  prcu_pkg::rot_lane_t rl2 [CORDIC_STEPS+1];
  prcu_pkg::side_t     rsb [CORDIC_STEPS+1];
  logic                b_v_q;
  prcu_pkg::rot_lane_t b_l1_q, b_l2_q;
  prcu_pkg::side_t     b_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_l1_q <= b_l1_d;
      b_l2_q <= b_l2_d;
      b_sb_q <= b_sb_d;
    end
  end

  assign rv[0]  = b_v_q;
  assign rl1[0] = b_l1_q;
  assign rl2[0] = b_l2_q;
  assign rsb[0] = b_sb_q;

  // rotation cell row
  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_rot
    prcu_rot_cell #(
      .STEP (gi)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (rv[gi]),
      .lane_a_i (rl1[gi]),
      .lane_b_i (rl2[gi]),
      .side_i   (rsb[gi]),
      .valid_o  (rv[gi+1]),
      .lane_a_o (rl1[gi+1]),
      .lane_b_o (rl2[gi+1]),
      .side_o   (rsb[gi+1])
    );
  end

  // --------------------------------------------------------------------------
  // C: cartesian rounding/saturation and component add or subtract
  // --------------------------------------------------------------------------
  // returns {saturated, value}
  function automatic logic [32:0] sat_coord(input logic signed [RW-1:0] g);
    logic signed [RW:0]   s;
    logic signed [RW-G:0] v;
    logic                 fits;
    s    = {g[RW-1], g} + ((RW+1)'(1) << (G - 1));
    v    = s[RW:G];
    fits = (&v[RW-G:31]) | ~(|v[RW-G:31]);
    if (fits) begin
      return {1'b0, v[31:0]};
    end else if (v[RW-G]) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b1, 32'h7FFF_FFFF};
  endfunction

  logic [32:0]          cx, cy;
  logic signed [VW-1:0] c1x, c1y, c2x, c2y, c_sx_d, c_sy_d;
  prcu_pkg::side_t      c_sb_d;

  always_comb begin
    cx     = sat_coord(rl1[CORDIC_STEPS].x);
    cy     = sat_coord(rl1[CORDIC_STEPS].y);
    c_sb_d = rsb[CORDIC_STEPS];
    if (c_sb_d.mode == prcu_pkg::MODE_P2R) begin
      c_sb_d.xo = cx[31:0];
      c_sb_d.yo = cy[31:0];
      c_sb_d.ov = c_sb_d.ov | cx[32] | cy[32];
    end
    c1x = {{(VW-RW){rl1[CORDIC_STEPS].x[RW-1]}}, rl1[CORDIC_STEPS].x};
    c1y = {{(VW-RW){rl1[CORDIC_STEPS].y[RW-1]}}, rl1[CORDIC_STEPS].y};
    c2x = {{(VW-RW){rl2[CORDIC_STEPS].x[RW-1]}}, rl2[CORDIC_STEPS].x};
    c2y = {{(VW-RW){rl2[CORDIC_STEPS].y[RW-1]}}, rl2[CORDIC_STEPS].y};
    if (c_sb_d.mode == prcu_pkg::MODE_SUB) begin
      c_sx_d = c1x - c2x;
      c_sy_d = c1y - c2y;
    end else begin
      c_sx_d = c1x + c2x;
      c_sy_d = c1y + c2y;
    end
  end

  logic                 c_v_q;
  logic signed [VW-1:0] c_sx_q, c_sy_q;
  prcu_pkg::side_t      c_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= rv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_sx_q <= c_sx_d;
      c_sy_q <= c_sy_d;
      c_sb_q <= c_sb_d;
    end
  end

  // --------------------------------------------------------------------------
  // D: zero-vector detect and fold into the right half plane
  // --------------------------------------------------------------------------
  prcu_pkg::vec_lane_t d_l_d;
  prcu_pkg::side_t     d_sb_d;

  always_comb begin
    d_sb_d      = c_sb_q;
    d_sb_d.zero = (c_sx_q == '0) && (c_sy_q == '0);
    if (c_sx_q[VW-1]) begin
      d_l_d.x = -c_sx_q;
      d_l_d.y = -c_sy_q;
      d_l_d.z = prcu_pkg::HALF_TURN;
    end else begin
      d_l_d.x = c_sx_q;
      d_l_d.y = c_sy_q;
      d_l_d.z = '0;
    end
  end

  logic                vv  [CORDIC_STEPS+1];
  prcu_pkg::vec_lane_t vl  [CORDIC_STEPS+1];
  prcu_pkg::side_t     vsb [CORDIC_STEPS+1];
  logic                d_v_q;
  prcu_pkg::vec_lane_t d_l_q;
  prcu_pkg::side_t     d_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_l_q  <= d_l_d;
      d_sb_q <= d_sb_d;
    end
  end

  assign vv[0]  = d_v_q;
  assign vl[0]  = d_l_q;
  assign vsb[0] = d_sb_q;

  // vectoring cell row
  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_vec
    prcu_vec_cell #(
      .STEP (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vv[gi]),
      .lane_i  (vl[gi]),
      .side_i  (vsb[gi]),
      .valid_o (vv[gi+1]),
      .lane_o  (vl[gi+1]),
      .side_o  (vsb[gi+1])
    );
  end

  // --------------------------------------------------------------------------
  // E/F: magnitude times 1/K (split product), then round-half-up add
  // --------------------------------------------------------------------------
  logic            e_v_q;
  logic [VW-1:0]   e_phi_q;
  logic [63:0]     e_plo_q;
  logic [31:0]     e_z_q;
  prcu_pkg::side_t e_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= vv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_phi_q <= {32'd0, vl[CORDIC_STEPS].x[VW-1:32]} *
                 {{(VW-32){1'b0}}, prcu_pkg::INV_GAIN};
      e_plo_q <= {32'd0, vl[CORDIC_STEPS].x[31:0]} * {32'd0, prcu_pkg::INV_GAIN};
      e_z_q   <= vl[CORDIC_STEPS].z;
      e_sb_q  <= vsb[CORDIC_STEPS];
    end
  end

  logic            f_v_q;
  logic [VW:0]     f_m_q;
  logic [31:0]     f_z_q;
  prcu_pkg::side_t f_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_m_q  <= {1'b0, e_phi_q} + (VW+1)'((e_plo_q + 64'h0000_0000_8000_0000) >> 32);
      f_z_q  <= e_z_q;
      f_sb_q <= e_sb_q;
    end
  end

  // final result select
  logic [VW:0]   mv;
  logic [VW-G:0] mg;
  logic          big, vec_mode;

  always_comb begin
    mv       = f_m_q + ((VW+1)'(1) << (G - 1));
    mg       = mv[VW:G];
    big      = |mg[VW-G:31];
    vec_mode = (f_sb_q.mode == prcu_pkg::MODE_R2P) ||
               (f_sb_q.mode == prcu_pkg::MODE_ADD) ||
               (f_sb_q.mode == prcu_pkg::MODE_SUB);
    res_d.xo  = f_sb_q.xo;
    res_d.yo  = f_sb_q.yo;
    res_d.ov  = f_sb_q.ov;
    res_d.rad = f_sb_q.rad;
    res_d.ang = f_sb_q.ang;
    if (vec_mode) begin
      if (f_sb_q.zero) begin
        res_d.rad = '0;
        res_d.ang = '0;
      end else begin
        res_d.rad = big ? 31'h7FFF_FFFF : mg[30:0];
        res_d.ang = f_z_q;
        res_d.ov  = f_sb_q.ov | big;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register plus one-entry skid
  // --------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= f_v_q;
      end
    end else if (en && f_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end
    if (!out_free && en && f_v_q) begin
      skid_q <= res_d;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.radius_out = out_q.rad;
  assign out_o.angle_out  = out_q.ang;
  assign out_o.x_out      = out_q.xo;
  assign out_o.y_out      = out_q.yo;
  assign out_o.overflow   = out_q.ov;

`ifndef SYNTHESIS
  // skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  // skid only fills when the output was held by the sink
  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_o.ready))
    else $error("skid register filled without output stall");

  // overflow always comes with a saturated field
  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.ov) |->
      (out_q.rad == 31'h7FFF_FFFF || out_q.xo == 32'h7FFF_FFFF ||
       out_q.xo == 32'h8000_0000 || out_q.yo == 32'h7FFF_FFFF ||
       out_q.yo == 32'h8000_0000))
    else $error("overflow flagged without a saturated field");
`endif

endmodule

// File: sim/prcu_point_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prcu_point_checker: result predictor and scoreboard for the point unit
// Watches both channels, computes the expected result of every accepted
// operation and compares it field by field with the next result.
// ----------------------------------------------------------------------------
module prcu_point_checker #(
  parameter int unsigned CORDIC_STEPS = 24,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  prcu_in_if   in_i,
  prcu_out_if  out_i,
  output int   err_cnt_o,
  output int   pending_o
);

  prcu_pkg::res_t expected_q[$];
  int             err_cnt;

  assign err_cnt_o = err_cnt;
  assign pending_o = expected_q.size();

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // (a * b + 2^31) >> 32 without losing the top bits
  function automatic longint unsigned mul_q32(longint unsigned a, logic [31:0] b);
    longint unsigned hi, lo, bb;
    hi = a >> 32;
    lo = a & 64'hFFFF_FFFF;
    bb = 64'(b);
    return hi * bb + ((lo * bb + 64'h8000_0000) >> 32);
  endfunction

  // signed radius to magnitude, negative flips the angle by half a turn
  function automatic void fold_radius(logic [31:0] r, logic [31:0] a,
                                      output longint unsigned mag,
                                      output logic [31:0] ang);
    longint rs;
    rs = sx32(r);
    ang = a;
    if (rs < 0) begin
      mag = longint'(-rs);
      ang = a + prcu_pkg::HALF_TURN;
    end else begin
      mag = longint'(rs);
    end
  endfunction

  function automatic void polar_to_xy(longint unsigned mag, logic [31:0] a,
                                      output longint xo, output longint yo);
    longint rg, x, y, z, dx, dy, t;
    logic [31:0] q;
    rg = longint'(mul_q32(mag << prcu_pkg::GUARD_BITS, prcu_pkg::INV_GAIN));
    y = 0;
    q = a + prcu_pkg::QUARTER_TURN;
    if (q[31]) begin
      x = -rg;
      z = sx32(a - prcu_pkg::HALF_TURN);
    end else begin
      x = rg;
      z = sx32(a);
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      t  = longint'(prcu_pkg::ATAN_TAB[i & 31]);
      if (z >= 0) begin
        x -= dx; y += dy; z -= t;
      end else begin
        x += dx; y -= dy; z += t;
      end
    end
    xo = x;
    yo = y;
  endfunction

  function automatic void xy_to_polar(longint xi, longint yi,
                                      output longint unsigned mag,
                                      output logic [31:0] ang);
    longint x, y, dx, dy;
    logic [31:0] z;
    x = xi;
    y = yi;
    z = '0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = '0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; z = prcu_pkg::HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += prcu_pkg::ATAN_TAB[i & 31];
      end else begin
        x -= dx; y += dy; z -= prcu_pkg::ATAN_TAB[i & 31];
      end
    end
    mag = (mul_q32(longint'(x), prcu_pkg::INV_GAIN) +
           (64'd1 << (prcu_pkg::GUARD_BITS - 1))) >> prcu_pkg::GUARD_BITS;
    ang = z;
  endfunction

  // guard-bit coordinate to rounded, saturated Q15.16
  function automatic logic [31:0] round_coord(longint g, inout logic ov);
    longint v;
    v = (g + (64'sd1 <<< (prcu_pkg::GUARD_BITS - 1))) >>> prcu_pkg::GUARD_BITS;
    if (v > 64'sd2147483647) begin
      ov = 1'b1; v = 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1; v = -64'sd2147483648;
    end
    return v[31:0];
  endfunction

  function automatic prcu_pkg::res_t predict_point(logic [2:0] mode, logic [31:0] x_in,
      logic [31:0] y_in, logic [31:0] rad, logic [31:0] ang_in, logic [31:0] dang,
      logic [31:0] fac, logic [31:0] orad, logic [31:0] oang);
    prcu_pkg::res_t r;
    longint unsigned mag, mag2;
    logic [31:0] ang, ang2;
    longint x1, y1, x2, y2;
    logic ov;
    r = '0;
    mag = 0;
    ang = '0;
    ov = 1'b0;
    case (mode)
      prcu_pkg::MODE_R2P: xy_to_polar(sx32(x_in) * 256, sx32(y_in) * 256, mag, ang);
      prcu_pkg::MODE_P2R: begin
        fold_radius(rad, ang_in, mag, ang);
        polar_to_xy(mag, ang, x1, y1);
        r.xo = round_coord(x1, ov);
        r.yo = round_coord(y1, ov);
      end
      prcu_pkg::MODE_ROT: begin
        fold_radius(rad, ang_in, mag, ang);
        ang += dang;
      end
      prcu_pkg::MODE_SCALE: begin
        fold_radius(rad, ang_in, mag, ang);
        fold_radius(fac, '0, mag2, ang2);
        ang += ang2;
        mag = (mag * mag2 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      end
      prcu_pkg::MODE_ADD, prcu_pkg::MODE_SUB: begin
        fold_radius(rad, ang_in, mag, ang);
        polar_to_xy(mag, ang, x1, y1);
        fold_radius(orad, oang, mag2, ang2);
        polar_to_xy(mag2, ang2, x2, y2);
        if (mode == prcu_pkg::MODE_SUB) begin
          x2 = -x2; y2 = -y2;
        end
        xy_to_polar(x1 + x2, y1 + y2, mag, ang);
      end
      default: ;  // unused codes give an all-zero result
    endcase
    if (mag > 64'h7FFF_FFFF) begin
      ov = 1'b1; mag = 64'h7FFF_FFFF;
    end
    r.rad = mag[30:0];
    r.ang = ang;
    r.ov  = ov;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_cnt <= 0;
      expected_q.delete();
    end else begin
      if (in_i.valid && in_i.ready)
        expected_q.push_back(predict_point(in_i.mode, in_i.x_in, in_i.y_in,
            in_i.radius_in, in_i.angle_in, in_i.delta_angle, in_i.scale_factor,
            in_i.other_radius, in_i.other_angle));
      if (out_i.valid && out_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no operation outstanding");
          err_cnt <= err_cnt + 1;
        end else begin
          prcu_pkg::res_t e;
          int bad;
          e = expected_q.pop_front();
          bad = 0;
          if (out_i.radius_out !== e.rad) begin
            $error("radius_out: expected %h, got %h", e.rad, out_i.radius_out);
            bad++;
          end
          if (out_i.angle_out !== e.ang) begin
            $error("angle_out: expected %h, got %h", e.ang, out_i.angle_out);
            bad++;
          end
          if (out_i.x_out !== e.xo) begin
            $error("x_out: expected %h, got %h", e.xo, out_i.x_out);
            bad++;
          end
          if (out_i.y_out !== e.yo) begin
            $error("y_out: expected %h, got %h", e.yo, out_i.y_out);
            bad++;
          end
          if (out_i.overflow !== e.ov) begin
            $error("overflow: expected %b, got %b", e.ov, out_i.overflow);
            bad++;
          end
          err_cnt <= err_cnt + bad;
        end
      end
    end
  end

endmodule

// File: sim/polar_rectangular_point_unit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polar_rectangular_point_unit_top_tb: stimulus and verdict for the point unit
// Directed corner operations, then random operations of every mode with
// random gaps on the sender and random stalls on the receiver, including one
// long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module polar_rectangular_point_unit_top_tb;

  localparam int unsigned STEPS    = 24;
  localparam int          N_RANDOM = 1130;
  localparam int          LATENCY  = 2 * STEPS + 8;

  // codes with no operation behind them
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  prcu_in_if  op_ch ();
  prcu_out_if res_ch ();

  int err_cnt, pending;
  int sent_cnt  = 0;
  int recv_cnt  = 0;
  int mode_cnt[8];
  bit stim_done = 1'b0;

  always #2 clk_i = ~clk_i;

  polar_rectangular_point_unit_top #(.CORDIC_STEPS(STEPS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_ch),
    .out_o (res_ch)
  );

  prcu_point_checker #(.CORDIC_STEPS(STEPS)) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (op_ch),
    .out_i    (res_ch),
    .err_cnt_o(err_cnt),
    .pending_o(pending)
  );

  // Known values on every input from time zero.
  initial begin
    op_ch.valid        = 1'b0;
    op_ch.mode         = prcu_pkg::MODE_R2P;
    op_ch.x_in         = '0;
    op_ch.y_in         = '0;
    op_ch.radius_in    = '0;
    op_ch.angle_in     = '0;
    op_ch.delta_angle  = '0;
    op_ch.scale_factor = '0;
    op_ch.other_radius = '0;
    op_ch.other_angle  = '0;
    res_ch.ready       = 1'b0;
  end

  // Sender gap per transaction, drawn at random, with a quiet stretch at full rate.
  function automatic int draw_gap(int idx);
    if (idx >= 400 && idx < 550) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
  endfunction

  // Coordinate / radius values: mostly moderate, with extremes and full range.
  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3:       begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hFFFF_FFFF;
          3: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      4, 5:    return 32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
      default: return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
    endcase
  endfunction

  // Scale factors near unity keep most products in range.
  function automatic logic [31:0] draw_factor();
    if ($urandom_range(0, 3) == 0) return draw_value();
    return 32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
  endfunction

  task automatic send_op(logic [2:0] mode, logic [31:0] x, logic [31:0] y,
                         logic [31:0] r, logic [31:0] a, logic [31:0] d,
                         logic [31:0] f, logic [31:0] orad, logic [31:0] oang);
    int gap;
    gap = draw_gap(sent_cnt);
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_ch.valid        <= 1'b1;
    op_ch.mode         <= mode;
    op_ch.x_in         <= x;
    op_ch.y_in         <= y;
    op_ch.radius_in    <= r;
    op_ch.angle_in     <= a;
    op_ch.delta_angle  <= d;
    op_ch.scale_factor <= f;
    op_ch.other_radius <= orad;
    op_ch.other_angle  <= oang;
    @(posedge clk_i);
    while (!op_ch.ready) @(posedge clk_i);
    sent_cnt++;
    mode_cnt[mode]++;
  endtask

  // Stimulus
  initial begin
    logic [2:0]  m;
    logic [31:0] r, a, orad, oang;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: zero vector, extremes, negative radius, -2^31 radius,
    // scale saturation and rounding, cancelling subtract, unused modes.
    send_op(prcu_pkg::MODE_R2P, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0);
    send_op(prcu_pkg::MODE_R2P, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_op(prcu_pkg::MODE_R2P, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    send_op(prcu_pkg::MODE_R2P, 32'hFFFF_FFFF, 32'h0, 0, 0, 0, 0, 0, 0);
    send_op(prcu_pkg::MODE_R2P, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_op(prcu_pkg::MODE_P2R, 0, 0, 32'h8000_0000, 32'h0, 0, 0, 0, 0);
    send_op(prcu_pkg::MODE_P2R, 0, 0, 32'h7FFF_FFFF, 32'h2000_0000, 0, 0, 0, 0);
    send_op(prcu_pkg::MODE_P2R, 0, 0, 32'h0, 32'h1234_5678, 0, 0, 0, 0);
    send_op(prcu_pkg::MODE_P2R, 0, 0, 32'hFFFF_0000, 32'h4000_0000, 0, 0, 0, 0);
    send_op(prcu_pkg::MODE_P2R, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_op(prcu_pkg::MODE_ROT, 0, 0, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 0, 0, 0);
    send_op(prcu_pkg::MODE_ROT, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
            0, 0, 0);
    send_op(prcu_pkg::MODE_SCALE, 0, 0, 32'h7FFF_FFFF, 32'h0, 0, 32'h7FFF_FFFF, 0, 0);
    send_op(prcu_pkg::MODE_SCALE, 0, 0, 32'h8000_0000, 32'h1000_0000, 0,
            32'h8000_0000, 0, 0);
    send_op(prcu_pkg::MODE_SCALE, 0, 0, 32'h0000_0001, 32'h0, 0, 32'h0000_8000, 0, 0);
    send_op(prcu_pkg::MODE_SCALE, 0, 0, 32'h0001_8000, 32'h0, 0, 32'hFFFF_8000, 0, 0);
    send_op(prcu_pkg::MODE_ADD, 0, 0, 32'h0001_0000, 32'h1000_0000, 0, 0,
            32'h0001_0000, 32'h1000_0000);
    send_op(prcu_pkg::MODE_SUB, 0, 0, 32'h0003_0000, 32'h5000_0000, 0, 0,
            32'h0003_0000, 32'h5000_0000);
    send_op(prcu_pkg::MODE_ADD, 0, 0, 32'h8000_0000, 32'h0, 0, 0, 32'h8000_0000, 32'h0);
    send_op(prcu_pkg::MODE_SUB, 0, 0, 32'h7FFF_FFFF, 32'h0, 0, 0, 32'h8000_0000, 32'h0);
    send_op(MODE_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(MODE_SPARE_HI, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0);

    // Random operations; unused codes only now and then.
    for (int i = 0; i < N_RANDOM; i++) begin
      m = ($urandom_range(0, 39) == 0) ?
            3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)) :
            3'($urandom_range(prcu_pkg::MODE_R2P, prcu_pkg::MODE_SUB));
      r    = draw_value();
      a    = $urandom();
      orad = draw_value();
      // sometimes the second point mirrors the first, to exercise cancellation
      oang = ($urandom_range(0, 7) == 0) ? a : $urandom();
      if (m == prcu_pkg::MODE_SUB && $urandom_range(0, 7) == 0) orad = r;
      send_op(m, draw_value(), draw_value(), r, a, $urandom(), draw_factor(),
              orad, oang);
    end
    op_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls, one long hold-off so the unit fills and
  // pushes back on the operation channel.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (recv_cnt == 300) stall = 4 * LATENCY;
      else if (recv_cnt >= 700 && recv_cnt < 850) stall = 0;
      else stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
      recv_cnt++;
    end
  end

  // Verdict
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("covered %0d transactions: r2p %0d, p2r %0d, rotate %0d, scale %0d",
             sent_cnt, mode_cnt[prcu_pkg::MODE_R2P], mode_cnt[prcu_pkg::MODE_P2R],
             mode_cnt[prcu_pkg::MODE_ROT], mode_cnt[prcu_pkg::MODE_SCALE]);
    $display("  add %0d, subtract %0d, unused codes %0d, results checked %0d",
             mode_cnt[prcu_pkg::MODE_ADD], mode_cnt[prcu_pkg::MODE_SUB],
             mode_cnt[MODE_SPARE_LO] + mode_cnt[MODE_SPARE_HI], recv_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/prcu_pkg.sv
hw/rtl/prcu_in_if.sv
hw/rtl/prcu_out_if.sv
hw/rtl/prcu_rot_cell.sv
hw/rtl/prcu_vec_cell.sv
hw/rtl/polar_rectangular_point_unit_top.sv
sim/prcu_point_checker.sv
sim/polar_rectangular_point_unit_top_tb.sv
